// ===== design/mdpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mdpd_pkg
// Shared constants, codes and types of the magic-delimited packet deframer.
// ----------------------------------------------------------------------------
package mdpd_pkg;

  // Delimiter length in bytes and derived widths.
  localparam int MAGIC_BYTES = 4;
  localparam int WIN_W       = 8 * MAGIC_BYTES;

  // Configuration port.
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC_PATTERN  = 1'd0,
    REG_MAX_PACKET_LEN = 1'd1
  } cfg_reg_t;

  localparam logic [31:0] MAGIC_RESET   = 32'd0;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1033;

  // Length counter.
  localparam int               CNT_W   = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] MB_CNT  = CNT_W'(MAGIC_BYTES);
  localparam logic [CNT_W-1:0] TWO_MB  = CNT_W'(2 * MAGIC_BYTES);

  // Result codes.
  localparam logic [1:0] KIND_OPCODE  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;

  // Framing state.
  typedef enum logic {
    ST_HUNT   = 1'b0,
    ST_PACKET = 1'b1
  } frame_state_t;

  // Output queue.
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } res_msg_t;

endpackage

// ===== design/mdpd_if.sv =====
// ----------------------------------------------------------------------------
// mdpd_rx_if / mdpd_tx_if
// Valid/ready channels for received bytes and for deframed result words.
// ----------------------------------------------------------------------------
interface mdpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface mdpd_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output kind, output status,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input status,
                  input last, output ready);
endinterface

// ===== design/mdpd_cell.sv =====
// ----------------------------------------------------------------------------
// mdpd_cell
// One byte position of the delimiter window: holds a byte, passes it on to
// the next older position on every shift and compares it with its magic byte.
// ----------------------------------------------------------------------------
module mdpd_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] magic_byte,
  output logic [7:0] byte_q,
  output logic       hit
);

  // Byte storage, loaded from the younger neighbor on every shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_q <= 8'd0;
    end else if (shift_en) begin
      byte_q <= byte_in;
    end
  end

  // Local compare against this position's delimiter byte.
  assign hit = (byte_q == magic_byte);

endmodule

// ===== design/mdpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdpd_ctrl
// Framing controller: tracks hunt/packet state and the saturating length
// count, and forms one result word per window position when one is due.
// ----------------------------------------------------------------------------
module mdpd_ctrl import mdpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        win_v,
  input  logic        match,
  input  logic [7:0]  oldest_byte,
  input  logic [15:0] max_len,
  output res_msg_t    res
);

  frame_state_t     state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] cnt_inc;
  logic             footer;

  // Saturating increment of the length count.
  assign cnt_inc = (cnt == CNT_MAX) ? cnt : cnt + CNT_W'(1);
  assign footer  = match && (cnt_inc >= TWO_MB);

  // Next state and next count.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    if (win_v) begin
      case (state)
        ST_HUNT: begin
          if (match && (cnt_inc >= MB_CNT)) begin
            state_next = ST_PACKET;
            cnt_next   = MB_CNT;
          end else begin
            cnt_next = cnt_inc;
          end
        end
        ST_PACKET: begin
          if (footer) begin
            // A good footer ends the packet; a rejected one opens the next.
            if ((cnt_inc != TWO_MB) && (cnt_inc <= max_len)) begin
              state_next = ST_HUNT;
              cnt_next   = '0;
            end else begin
              cnt_next = MB_CNT;
            end
          end else begin
            cnt_next = cnt_inc;
          end
        end
        default: begin
          state_next = ST_HUNT;
          cnt_next   = '0;
        end
      endcase
    end
  end

  // Result word for this window position.
  always_comb begin
    res = '0;
    case (state)
      ST_HUNT: begin
        res.valid = 1'b0;
      end
      ST_PACKET: begin
        if (win_v && footer) begin
          res.valid       = 1'b1;
          res.data.kind   = KIND_END;
          res.data.last   = 1'b1;
          if (cnt_inc == TWO_MB) begin
            res.data.status = STATUS_EMPTY;
          end else if (cnt_inc > max_len) begin
            res.data.status = STATUS_TOO_LONG;
          end else begin
            res.data.status = STATUS_GOOD;
          end
        end else if (win_v && (cnt_inc >= TWO_MB)) begin
          res.valid         = 1'b1;
          res.data.out_byte = oldest_byte;
          res.data.kind     = (cnt_inc == TWO_MB) ? KIND_OPCODE : KIND_PAYLOAD;
        end
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== design/mdpd_outbuf.sv =====
// ----------------------------------------------------------------------------
// mdpd_outbuf
// Three-word output queue. It reserves room for the word still in the window
// stage, so a result in flight always finds a free slot.
// ----------------------------------------------------------------------------
module mdpd_outbuf import mdpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  res_msg_t  res,
  input  logic      win_v,
  output logic      has_room,
  mdpd_tx_if.source tx
);

  result_t               slot [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] cnt;
  logic                  push, pop;
  logic [FIFO_CNT_W:0]   occupancy;

  assign push = res.valid;
  assign pop  = tx.valid && tx.ready;

  // Room for one more byte counts the queue and the word in the window stage.
  assign occupancy = {1'b0, cnt} + (FIFO_CNT_W+1)'(win_v);
  assign has_room  = (occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH));

  // Head of the queue drives the channel.
  assign tx.valid    = (cnt != '0);
  assign tx.out_byte = slot[rd_ptr].out_byte;
  assign tx.kind     = slot[rd_ptr].kind;
  assign tx.status   = slot[rd_ptr].status;
  assign tx.last     = slot[rd_ptr].last;

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= res.data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        cnt <= cnt - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/magic_delimited_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// magic_delimited_packet_deframer
// Finds packets framed by a magic word at both ends in a byte stream and
// emits opcode, payload and end-marker words.
//
//   Channel  Dir  Word                           Handshake
//   rx_ch    in   in_byte[7:0]                   valid/ready
//   tx_ch    out  out_byte[7:0] kind status last valid/ready
//   cfg      in   cfg_index, cfg_data[31:0]      cfg_we, no back-pressure
//
// One byte is taken per cycle while rx_ch.ready is high. A byte shifts into
// the cell row at acceptance; its result word enters the output queue on
// the next cycle. rx_ch.ready drops only when the three-word output queue
// and the window stage together are full.
// Synchronous reset clears the window, framing state and queue; the
// registers return to magic 0 and limit 1033.
// ----------------------------------------------------------------------------
module magic_delimited_packet_deframer import mdpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  mdpd_rx_if.sink              rx_ch,
  mdpd_tx_if.source            tx_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [31:0]      magic_pattern;
  logic [15:0]      max_packet_len;
  logic [WIN_W-1:0] magic_ext;
  logic             accept;
  logic             win_v;
  logic             has_room;
  logic [7:0]       link [MAGIC_BYTES+1];
  logic [MAGIC_BYTES-1:0] hit;
  res_msg_t         res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_pattern  <= MAGIC_RESET;
      max_packet_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAGIC_PATTERN:  magic_pattern  <= cfg_data[31:0];
        REG_MAX_PACKET_LEN: max_packet_len <= cfg_data[15:0];
        default: begin
          magic_pattern <= magic_pattern;
        end
      endcase
    end
  end

  // Delimiter bytes above bit 31 read as zero.
  assign magic_ext = WIN_W'(magic_pattern);

  // Input handshake.
  assign rx_ch.ready = has_room;
  assign accept      = rx_ch.valid && rx_ch.ready;

  // Window stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_v <= 1'b0;
    end else begin
      win_v <= accept;
    end
  end

  // Row of window cells, newest byte in cell 0.
  assign link[0] = rx_ch.in_byte;

  for (genvar k = 0; k < MAGIC_BYTES; k++) begin : g_cell
    mdpd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift_en   (accept),
      .byte_in    (link[k]),
      .magic_byte (magic_ext[8*k +: 8]),
      .byte_q     (link[k+1]),
      .hit        (hit[k])
    );
  end

  // Framing control.
  mdpd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .win_v       (win_v),
    .match       (&hit),
    .oldest_byte (link[MAGIC_BYTES]),
    .max_len     (max_packet_len),
    .res         (res)
  );

  // Output queue.
  mdpd_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .win_v    (win_v),
    .has_room (has_room),
    .tx       (tx_ch)
  );

endmodule

// ===== design/mdpd_checker.sv =====
// ----------------------------------------------------------------------------
// mdpd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
module mdpd_checker import mdpd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] out_byte,
  input logic [1:0] kind,
  input logic [1:0] status,
  input logic       last
);

  // A stalled word stays put.
  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(out_byte) && $stable(kind)
                              && $stable(status) && $stable(last))
    else $error("result word changed while stalled");

  // The end marker and only the end marker carries last.
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    tx_valid |-> (last == (kind == KIND_END)))
    else $error("last does not match end marker");

  // Content words carry no status.
  a_content_status: assert property (@(posedge clk) disable iff (rst)
    tx_valid && (kind != KIND_END) |->
      (status == STATUS_GOOD) && ((kind == KIND_OPCODE) || (kind == KIND_PAYLOAD)))
    else $error("bad content word");

  // End markers carry a zero byte and a defined status.
  a_end_word: assert property (@(posedge clk) disable iff (rst)
    tx_valid && (kind == KIND_END) |->
      (out_byte == 8'd0) && ((status == STATUS_GOOD) || (status == STATUS_TOO_LONG)
                             || (status == STATUS_EMPTY)))
    else $error("bad end marker");

endmodule

bind magic_delimited_packet_deframer mdpd_checker u_mdpd_checker (
  .clk      (clk),
  .rst      (rst),
  .tx_valid (tx_ch.valid),
  .tx_ready (tx_ch.ready),
  .out_byte (tx_ch.out_byte),
  .kind     (tx_ch.kind),
  .status   (tx_ch.status),
  .last     (tx_ch.last)
);
